// ===== design/ehcd_pkg.sv =====
// shared types and constants of the elevator hall-call dispatcher
// no dependencies; used by every design file
package ehcd_pkg;

    localparam int MAX_CARS_DEF   = 8;
    localparam int MAX_FLOORS_DEF = 64;

    localparam int FUNC_W      = 2;
    localparam int FLOOR_IN_W  = 6;
    localparam int CAR_ID_W    = 3;
    localparam int MODE_W      = 2;
    localparam int CAR_OUT_W   = 3;
    localparam int CAR_CNT_W   = 4;
    localparam int FLOOR_CNT_W = 7;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CAR_CNT_W-1:0]   CAR_COUNT_RST   = 4'd2;
    localparam logic [FLOOR_CNT_W-1:0] FLOOR_COUNT_RST = 7'd20;

    // item function codes
    localparam logic [FUNC_W-1:0] FUNC_CALL   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_STATUS = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_ARRIVE = 2'd2;

    // car modes
    localparam logic [MODE_W-1:0] MODE_IDLE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_UP   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DOWN = 2'd2;
    localparam logic [MODE_W-1:0] MODE_OPEN = 2'd3;

    // call directions, also the bit position of the lamp in a lamp entry
    localparam logic DIR_UP   = 1'b0;
    localparam logic DIR_DOWN = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CAR_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_COUNT = 2'd1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    // outcome of the car scan
    typedef struct packed {
        logic                 stopped;
        logic [CAR_OUT_W-1:0] car;
    } t_pick;

endpackage

// ===== design/ehcd_pick.sv =====
// nearest-car selection: takes one car record per cycle and keeps the best candidates
// depends on ehcd_pkg
module ehcd_pick #(
    parameter int  MAX_CARS   = ehcd_pkg::MAX_CARS_DEF,
    parameter int  MAX_FLOORS = ehcd_pkg::MAX_FLOORS_DEF,
    localparam int CW         = (MAX_CARS > 1) ? $clog2(MAX_CARS) : 1,
    localparam int FW         = $clog2(MAX_FLOORS)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_clear,
    input  logic                          i_vld,
    input  logic [CW-1:0]                 i_idx,
    input  logic [FW-1:0]                 i_car_floor,
    input  logic [ehcd_pkg::MODE_W-1:0]   i_car_mode,
    input  logic [FW-1:0]                 i_call_floor,
    input  logic                          i_call_dir,
    output ehcd_pkg::t_pick               o_res
);
    import ehcd_pkg::*;

    localparam int IEW = (CW > CAR_OUT_W) ? CW : CAR_OUT_W;

    logic          r_idle_found;
    logic [FW-1:0] r_idle_dist;
    logic [CW-1:0] r_idle_car;
    logic          r_dir_found;
    logic [FW-1:0] r_dir_dist;
    logic [CW-1:0] r_dir_car;
    logic          r_stopped;

    logic [FW-1:0]  w_dist;
    logic           w_is_idle;
    logic           w_dir_ok;
    logic           w_stop;
    logic           w_take_idle;
    logic           w_take_dir;
    logic [IEW-1:0] w_sel;

    always_comb begin
        w_dist    = (i_car_floor > i_call_floor) ? (i_car_floor - i_call_floor)
                                                 : (i_call_floor - i_car_floor);
        w_is_idle = (i_car_mode == MODE_IDLE);
        w_dir_ok  = ((i_car_mode == MODE_UP) && (i_call_dir == DIR_UP)
                        && (i_car_floor <= i_call_floor))
                 || ((i_car_mode == MODE_DOWN) && (i_call_dir == DIR_DOWN)
                        && (i_car_floor >= i_call_floor));
        w_stop    = (i_car_floor == i_call_floor)
                 && ((i_car_mode == MODE_IDLE) || (i_car_mode == MODE_OPEN));
        // strict compare keeps the lower index on ties
        w_take_idle = i_vld && w_is_idle && (!r_idle_found || (w_dist < r_idle_dist));
        w_take_dir  = i_vld && w_dir_ok && (!r_dir_found || (w_dist < r_dir_dist));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_idle_found <= 1'b0;
            r_dir_found  <= 1'b0;
            r_stopped    <= 1'b0;
        end else begin
            if (w_take_idle) begin
                r_idle_found <= 1'b1;
            end
            if (w_take_dir) begin
                r_dir_found <= 1'b1;
            end
            if (i_vld && w_stop) begin
                r_stopped <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take_idle) begin
            r_idle_dist <= w_dist;
            r_idle_car  <= i_idx;
        end
        if (w_take_dir) begin
            r_dir_dist <= w_dist;
            r_dir_car  <= i_idx;
        end
    end

    // idle cars first, then cars heading toward the floor, else car 0
    always_comb begin
        if (r_idle_found) begin
            w_sel = IEW'(r_idle_car);
        end else if (r_dir_found) begin
            w_sel = IEW'(r_dir_car);
        end else begin
            w_sel = '0;
        end
        o_res.stopped = r_stopped;
        o_res.car     = w_sel[CAR_OUT_W-1:0];
    end

endmodule

// ===== design/elevator_hall_call_dispatch.sv =====
// Hall-call dispatcher. One item in, one result out. A hall call that passes the floor and
// direction checks is scanned against every car in service (1..MAX_CARS) before its result
// reaches the result register; a status update, an arrival, an unused code or a rejected hall
// call skips the scan. After each item the block returns to its idle state, where the next item
// is taken. The scan runs on the car table, which has one read port and is read one car per
// cycle; the lamp table is read at the item's floor and written back at the end. The next item
// is accepted as soon as the result is registered, even if the result is not yet taken; that
// item then holds in its last cycle until the waiting result leaves. Tables come out of reset
// cleared (per-entry valid bits), so no clearing pass is needed. The configuration port is
// always ready.
// depends on ehcd_pkg and ehcd_pick
module elevator_hall_call_dispatch #(
    parameter int MAX_CARS   = ehcd_pkg::MAX_CARS_DEF,
    parameter int MAX_FLOORS = ehcd_pkg::MAX_FLOORS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ehcd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ehcd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // input items
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [ehcd_pkg::FUNC_W-1:0]       i_func,
    input  logic [ehcd_pkg::FLOOR_IN_W-1:0]   i_floor,
    input  logic                              i_call_dir,
    input  logic [ehcd_pkg::CAR_ID_W-1:0]     i_car_id,
    input  logic [ehcd_pkg::MODE_W-1:0]       i_car_mode,
    // result items
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_assign_valid,
    output logic [ehcd_pkg::CAR_OUT_W-1:0]    o_assigned_car,
    output logic                              o_up_lamp,
    output logic                              o_down_lamp
);
    import ehcd_pkg::*;

    localparam int CW  = (MAX_CARS > 1) ? $clog2(MAX_CARS) : 1;
    localparam int CNW = $clog2(MAX_CARS + 1);
    localparam int FW  = $clog2(MAX_FLOORS);
    localparam int FEW = (FW > FLOOR_IN_W) ? FW : FLOOR_IN_W;
    localparam int IEW = (CW > CAR_ID_W) ? CW : CAR_ID_W;
    localparam int RW  = MODE_W + FW;

    // configuration
    logic [CAR_CNT_W-1:0]   r_car_count;
    logic [FLOOR_CNT_W-1:0] r_floor_count;

    // sequencer
    t_state         r_state;
    t_state         n_state;
    logic [CNW-1:0] r_idx;
    logic           r_dv;
    logic [CW-1:0]  r_dv_idx;

    // latched item
    logic [FUNC_W-1:0] r_func;
    logic [FEW-1:0]    r_floor;
    logic              r_dir;
    logic [IEW-1:0]    r_id;
    logic [MODE_W-1:0] r_mode;

    // car table: {mode, floor}
    logic [RW-1:0]       r_car_mem [MAX_CARS];
    logic [MAX_CARS-1:0] r_car_ok;
    logic [RW-1:0]       r_car_q;
    logic                r_car_q_ok;

    // lamp table: bit 0 up, bit 1 down
    logic [1:0]            r_lamp_mem [MAX_FLOORS];
    logic [MAX_FLOORS-1:0] r_lamp_ok;
    logic [1:0]            r_lamp_q;
    logic                  r_lamp_q_ok;

    // result register
    logic                 r_out_valid;
    logic                 r_assign_valid;
    logic [CAR_OUT_W-1:0] r_assigned_car;
    logic                 r_up_lamp;
    logic                 r_down_lamp;

    logic           w_accept;
    logic           w_issue;
    logic           w_fire;
    logic [CNW-1:0] w_ncars;
    logic           w_call_ok;
    logic           w_status_ok;
    logic           w_arrive_ok;
    logic           w_fl_in;
    logic [CNW-1:0] w_scan_n;
    logic [RW-1:0]  w_car_rec;
    logic [1:0]     w_lamp_cur;
    logic [1:0]     w_lamp_new;
    logic           w_lamp_wr;
    t_pick          w_pick;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_car_count   <= CAR_COUNT_RST;
            r_floor_count <= FLOOR_COUNT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_CAR_COUNT:   r_car_count   <= i_cfg_data[CAR_CNT_W-1:0];
                CFG_FLOOR_COUNT: r_floor_count <= i_cfg_data[FLOOR_CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp the registers into range and classify the latched item
    always_comb begin
        int nc;
        int nf;
        int fl;
        nc = int'(r_car_count);
        nf = int'(r_floor_count);
        fl = int'(r_floor);
        if (nc < 1) begin
            nc = 1;
        end
        if (nc > MAX_CARS) begin
            nc = MAX_CARS;
        end
        if (nf < 2) begin
            nf = 2;
        end
        if (nf > MAX_FLOORS) begin
            nf = MAX_FLOORS;
        end
        w_ncars     = CNW'(nc);
        w_fl_in     = (fl < MAX_FLOORS);
        w_call_ok   = (r_func == FUNC_CALL) && (fl < nf)
                   && !((r_dir == DIR_UP) && (fl == nf - 1))
                   && !((r_dir == DIR_DOWN) && (fl == 0));
        w_status_ok = (r_func == FUNC_STATUS) && (int'(r_id) < nc) && (fl < nf);
        w_arrive_ok = (r_func == FUNC_ARRIVE) && (fl < nf);
        w_scan_n    = w_call_ok ? w_ncars : '0;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_idx == w_scan_n) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_ready = 1'b0;
        w_issue    = 1'b0;
        w_fire     = 1'b0;
        case (r_state)
            S_IDLE:   o_in_ready = 1'b1;
            S_SCAN:   w_issue    = (r_idx != w_scan_n);
            S_FINISH: w_fire     = !r_out_valid || i_out_ready;
            default: ;
        endcase
        w_accept = o_in_ready && i_in_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_dv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dv    <= w_issue;
            if (w_accept) begin
                r_idx <= '0;
            end else if (w_issue) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func  <= i_func;
            r_floor <= FEW'(i_floor);
            r_dir   <= i_call_dir;
            r_id    <= IEW'(i_car_id);
            r_mode  <= i_car_mode;
        end
    end

    // car table: one read per scan cycle, written back by a status update
    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_car_q    <= r_car_mem[r_idx[CW-1:0]];
            r_car_q_ok <= r_car_ok[r_idx[CW-1:0]];
            r_dv_idx   <= r_idx[CW-1:0];
        end
        if (w_fire && w_status_ok) begin
            r_car_mem[r_id[CW-1:0]] <= {r_mode, r_floor[FW-1:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_car_ok <= '0;
        end else if (w_fire && w_status_ok) begin
            r_car_ok[r_id[CW-1:0]] <= 1'b1;
        end
    end

    assign w_car_rec = r_car_q_ok ? r_car_q : '0;

    ehcd_pick #(
        .MAX_CARS   (MAX_CARS),
        .MAX_FLOORS (MAX_FLOORS)
    ) u_pick (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_clear      (w_accept),
        .i_vld        (r_dv),
        .i_idx        (r_dv_idx),
        .i_car_floor  (w_car_rec[FW-1:0]),
        .i_car_mode   (w_car_rec[RW-1:FW]),
        .i_call_floor (r_floor[FW-1:0]),
        .i_call_dir   (r_dir),
        .o_res        (w_pick)
    );

    // lamp table: read at the item's floor, modified and written back when the item retires
    always_ff @(posedge i_clk) begin
        r_lamp_q    <= r_lamp_mem[r_floor[FW-1:0]];
        r_lamp_q_ok <= r_lamp_ok[r_floor[FW-1:0]];
        if (w_fire && w_lamp_wr) begin
            r_lamp_mem[r_floor[FW-1:0]] <= w_lamp_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lamp_ok <= '0;
        end else if (w_fire && w_lamp_wr) begin
            r_lamp_ok[r_floor[FW-1:0]] <= 1'b1;
        end
    end

    always_comb begin
        w_lamp_cur = (w_fl_in && r_lamp_q_ok) ? r_lamp_q : 2'b00;
        w_lamp_new = w_lamp_cur;
        // no lamp when a car already stands at the floor
        w_lamp_wr  = (w_call_ok && !w_pick.stopped) || w_arrive_ok;
        if (w_call_ok && !w_pick.stopped) begin
            w_lamp_new[r_dir] = 1'b1;
        end
        if (w_arrive_ok) begin
            w_lamp_new = 2'b00;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_assign_valid <= w_call_ok;
            r_assigned_car <= w_call_ok ? w_pick.car : '0;
            r_up_lamp      <= w_fl_in && w_lamp_new[DIR_UP];
            r_down_lamp    <= w_fl_in && w_lamp_new[DIR_DOWN];
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_assign_valid = r_assign_valid;
    assign o_assigned_car = r_assigned_car;
    assign o_up_lamp      = r_up_lamp;
    assign o_down_lamp    = r_down_lamp;

endmodule

// ===== design/ehcd_checker.sv =====
// port-level checks of the hall-call dispatcher, bound to the top level
// depends on ehcd_pkg and elevator_hall_call_dispatch
module ehcd_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_ready,
    input logic                              o_out_valid,
    input logic                              i_out_ready,
    input logic                              o_assign_valid,
    input logic [ehcd_pkg::CAR_OUT_W-1:0]    o_assigned_car,
    input logic                              o_up_lamp,
    input logic                              o_down_lamp
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid
            && $stable({o_assign_valid, o_assigned_car, o_up_lamp, o_down_lamp}))
        else $error("result changed while stalled");

    // a result without a dispatch names car 0
    a_no_assign_car0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_assign_valid |-> o_assigned_car == '0)
        else $error("car index set without a dispatch");

    // the input is not ready in the cycle after an item is taken
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("two items taken back to back");

    // a new result only comes while the input side is busy
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(o_in_ready))
        else $error("result appeared with no item in work");

    // reset leaves the block empty and ready
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("block not empty after reset");

endmodule

bind elevator_hall_call_dispatch ehcd_checker u_ehcd_checker (.*);
